/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL. They compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

/* rtl/core/s2c_pkg.sv */
`timescale 1ns / 1ps
package s2c_pkg;

  // Widths of the rotation datapath (Q2.30 for x and y, angle in Q.30).
  localparam int XW      = 32;
  localparam int ZW      = 33;
  localparam int TAB_LEN = 24;

  // Angle constants in Q.30, wide enough to compare against any input angle.
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] NEG_PI_Q30  = -35'sd3373259426;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] NEG_HALF_PI = -35'sd1686629713;

  // Starting x of a rotation: the inverse of the rotation gain.
  localparam logic signed [XW-1:0] GAIN_Q30 = 32'sd652032874;

  // Rounding offsets for the shifts by 30 bits.
  localparam logic signed [63:0] RND64 = 64'sd536870912;
  localparam logic signed [47:0] RND48 = 48'sd536870912;

  // Output range of a Q8.8 field.
  localparam logic signed [47:0] OUT_MAX = 48'sd32767;
  localparam logic signed [47:0] OUT_MIN = -48'sd32768;

  typedef struct packed {
    logic signed [15:0] radius;
    logic signed [15:0] azimuth;
    logic signed [15:0] polar;
  } point_t;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } coord_t;

  // One rotation in flight: cosine, sine and the angle still to rotate.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // Everything one point carries down the chain of rotation cells.
  typedef struct packed {
    rot_t               az;
    rot_t               po;
    logic signed [15:0] radius;
    logic               flip_az;
    logic               flip_po;
  } cell_data_t;

  // Arctangent of 2^-idx in Q.30.
  function automatic logic signed [ZW-1:0] arc_angle(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = 33'sd843314857;
      1:       a = 33'sd497837829;
      2:       a = 33'sd263043837;
      3:       a = 33'sd133525159;
      4:       a = 33'sd67021687;
      5:       a = 33'sd33543516;
      6:       a = 33'sd16775851;
      7:       a = 33'sd8388437;
      8:       a = 33'sd4194283;
      9:       a = 33'sd2097149;
      10:      a = 33'sd1048576;
      11:      a = 33'sd524288;
      12:      a = 33'sd262144;
      13:      a = 33'sd131072;
      14:      a = 33'sd65536;
      15:      a = 33'sd32768;
      16:      a = 33'sd16384;
      17:      a = 33'sd8192;
      18:      a = 33'sd4096;
      19:      a = 33'sd2048;
      20:      a = 33'sd1024;
      21:      a = 33'sd512;
      22:      a = 33'sd256;
      23:      a = 33'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/core/s2c_prep.sv */
`timescale 1ns / 1ps
module s2c_prep import s2c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  point_t     point,
  output logic       out_vld,
  output cell_data_t out_data
);

  logic                 vld1;
  logic signed [15:0]   radius1;
  logic signed [ZW-1:0] red_az;
  logic signed [ZW-1:0] red_po;
  logic signed [ZW:0]   fold_az;
  logic signed [ZW:0]   fold_po;

  // Bring a Q4.12 angle to Q.30 and into [-pi, pi] with at most one add or subtract of 2*pi.
  function automatic logic signed [ZW-1:0] reduce(input logic signed [15:0] ang);
    logic signed [34:0] z0;
    logic signed [34:0] r;
    z0 = 35'(ang) <<< 18;
    if (z0 > PI_Q30) begin
      r = z0 - TWO_PI_Q30;
    end else if (z0 < NEG_PI_Q30) begin
      r = z0 + TWO_PI_Q30;
    end else begin
      r = z0;
    end
    return r[ZW-1:0];
  endfunction

  // Fold into [-pi/2, pi/2]; the top bit tells that the results change sign.
  function automatic logic signed [ZW:0] fold(input logic signed [ZW-1:0] z);
    logic signed [34:0] w;
    logic signed [34:0] r;
    logic               flip;
    w = 35'(z);
    flip = 1'b1;
    if (w > HALF_PI_Q30) begin
      r = w - PI_Q30;
    end else if (w < NEG_HALF_PI) begin
      r = w + PI_Q30;
    end else begin
      r = w;
      flip = 1'b0;
    end
    return {flip, r[ZW-1:0]};
  endfunction

  assign fold_az = fold(red_az);
  assign fold_po = fold(red_po);

  // Valid bits of the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  // First stage reduces, second stage folds and seeds the rotation.
  always_ff @(posedge clk) begin
    if (en) begin
      radius1          <= point.radius;
      red_az           <= reduce(point.azimuth);
      red_po           <= reduce(point.polar);
      out_data.radius  <= radius1;
      out_data.flip_az <= fold_az[ZW];
      out_data.flip_po <= fold_po[ZW];
      out_data.az.x    <= GAIN_Q30;
      out_data.az.y    <= '0;
      out_data.az.z    <= fold_az[ZW-1:0];
      out_data.po.x    <= GAIN_Q30;
      out_data.po.y    <= '0;
      out_data.po.z    <= fold_po[ZW-1:0];
    end
  end

endmodule

/* rtl/core/s2c_cell.sv */
`timescale 1ns / 1ps
module s2c_cell import s2c_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  cell_data_t in_data,
  output logic       out_vld,
  output cell_data_t out_data
);

  localparam logic signed [ZW-1:0] ARC = arc_angle(STEP);

  // One rotation step: turn toward zero residual angle by atan(2^-STEP).
  function automatic rot_t rotate(input rot_t r);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    rot_t                 n;
    dx = r.y >>> STEP;
    dy = r.x >>> STEP;
    if (r.z >= 0) begin
      n.x = r.x - dx;
      n.y = r.y + dy;
      n.z = r.z - ARC;
    end else begin
      n.x = r.x + dx;
      n.y = r.y - dy;
      n.z = r.z + ARC;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // Both angles rotate side by side; the rest rides along.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.az      <= rotate(in_data.az);
      out_data.po      <= rotate(in_data.po);
      out_data.radius  <= in_data.radius;
      out_data.flip_az <= in_data.flip_az;
      out_data.flip_po <= in_data.flip_po;
    end
  end

endmodule

/* rtl/core/s2c_post.sv */
`timescale 1ns / 1ps
module s2c_post import s2c_pkg::*; #(
  parameter int RES_W = 26
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  cell_data_t in_data,
  output logic [5:0] vld,
  output coord_t     coord
);

  localparam int PW = XW + RES_W;

  // Stage 1 registers: correction products.
  logic signed [PW-1:0] yz_az, xz_az, yz_po, xz_po;
  logic signed [XW-1:0] x1_az, y1_az, x1_po, y1_po;
  logic signed [15:0]   radius1, radius2, radius3, radius4;
  logic                 flip1_az, flip1_po;

  // Stage 2 registers: final cosines and sines.
  logic signed [XW-1:0] cp, sp, ct, st;

  // Stage 3 and 4 registers: angle products, then rounded.
  logic signed [63:0]   pxm, pym;
  logic signed [XW-1:0] ct3, px, py, ct4;

  // Stage 5 registers: scaled by the radius.
  logic signed [47:0]   rx, ry, rz;

  logic signed [RES_W-1:0] zr_az, zr_po;
  logic signed [XW-1:0]    cx_az, cy_az, cx_po, cy_po;

  // Round a Q.60 product to Q.30, ties upward.
  function automatic logic signed [XW-1:0] rnd64(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + RND64) >>> 30;
    return t[XW-1:0];
  endfunction

  // Round a Q.38 product to Q8.8 and clip to the field range.
  function automatic logic signed [15:0] rnd_sat(input logic signed [47:0] v);
    logic signed [47:0] t;
    logic signed [47:0] c;
    t = (v + RND48) >>> 30;
    if (t > OUT_MAX) begin
      c = OUT_MAX;
    end else if (t < OUT_MIN) begin
      c = OUT_MIN;
    end else begin
      c = t;
    end
    return c[15:0];
  endfunction

  // The residual angle is small after the last rotation step.
  assign zr_az = in_data.az.z[RES_W-1:0];
  assign zr_po = in_data.po.z[RES_W-1:0];

  // First-order correction with the residual angle.
  always_comb begin
    cx_az = x1_az - XW'(yz_az >>> 30);
    cy_az = y1_az + XW'(xz_az >>> 30);
    cx_po = x1_po - XW'(yz_po >>> 30);
    cy_po = y1_po + XW'(xz_po >>> 30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yz_az    <= in_data.az.y * zr_az;
      xz_az    <= in_data.az.x * zr_az;
      yz_po    <= in_data.po.y * zr_po;
      xz_po    <= in_data.po.x * zr_po;
      x1_az    <= in_data.az.x;
      y1_az    <= in_data.az.y;
      x1_po    <= in_data.po.x;
      y1_po    <= in_data.po.y;
      flip1_az <= in_data.flip_az;
      flip1_po <= in_data.flip_po;
      radius1  <= in_data.radius;

      cp      <= flip1_az ? -cx_az : cx_az;
      sp      <= flip1_az ? -cy_az : cy_az;
      ct      <= flip1_po ? -cx_po : cx_po;
      st      <= flip1_po ? -cy_po : cy_po;
      radius2 <= radius1;

      pxm     <= cp * st;
      pym     <= sp * st;
      ct3     <= ct;
      radius3 <= radius2;

      px      <= rnd64(pxm);
      py      <= rnd64(pym);
      ct4     <= ct3;
      radius4 <= radius3;

      rx <= radius4 * px;
      ry <= radius4 * py;
      rz <= radius4 * ct4;

      coord.coord_x <= rnd_sat(rx);
      coord.coord_y <= rnd_sat(ry);
      coord.coord_z <= rnd_sat(rz);
    end
  end

endmodule

/* rtl/core/spherical_to_cartesian.sv */
// Channel   Direction  Handshake                  Payload
// point     in         point_valid / point_stall  point_t (radius, azimuth, polar)
// coord     out        coord_valid / coord_stall  coord_t (coord_x, coord_y, coord_z)
//
// One request enters per cycle while no result is held under coord_stall; each result passes
// two angle reduction stages, one rotation cell per step and six output stages.
// Reset clears only the valid bits of the pipeline; nothing else needs clearing.
// While a result waits under coord_stall the whole pipeline holds and point_stall is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spherical_to_cartesian import s2c_pkg::*; #(
  parameter int ROTATION_STEPS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   point_valid,
  output logic   point_stall,
  input  point_t point,
  output logic   coord_valid,
  input  logic   coord_stall,
  output coord_t coord
);

  localparam int NSTEPS = (ROTATION_STEPS < TAB_LEN) ? ROTATION_STEPS : TAB_LEN;
  localparam int RES_W  = 34 - NSTEPS;

  logic              advance;
  logic [NSTEPS:0]   chain_vld;
  cell_data_t        chain_data [NSTEPS+1];
  logic [5:0]        post_vld;
  logic [NSTEPS+6:0] stage_vld;

  // The pipeline moves unless a finished result is held back.
  assign advance     = !(coord_valid && coord_stall);
  assign point_stall = !advance;
  assign coord_valid = post_vld[5];
  assign stage_vld   = {post_vld, chain_vld};

  s2c_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_vld   (point_valid),
    .point    (point),
    .out_vld  (chain_vld[0]),
    .out_data (chain_data[0])
  );

  // Chain of rotation cells, one per step.
  for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
    s2c_cell #(
      .STEP (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .in_vld   (chain_vld[i]),
      .in_data  (chain_data[i]),
      .out_vld  (chain_vld[i+1]),
      .out_data (chain_data[i+1])
    );
  end

  s2c_post #(
    .RES_W (RES_W)
  ) u_post (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .in_vld  (chain_vld[NSTEPS]),
    .in_data (chain_data[NSTEPS]),
    .vld     (post_vld),
    .coord   (coord)
  );

  // Pipeline control checks.
  `ASSERT_NEXT(a_hold_frozen, clk, rst, !advance, $stable(stage_vld), "pipeline moved while held")
  `ASSERT_NEXT(a_prep_to_cell, clk, rst, advance && chain_vld[0], chain_vld[1], "request lost entering the cells")
  `ASSERT_NEXT(a_cell_to_post, clk, rst, advance && chain_vld[NSTEPS], post_vld[0], "request lost leaving the cells")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench import s2c_pkg::*;;

  localparam int ROT_STEPS   = 16;
  localparam int PIPE_DEPTH  = ROT_STEPS + 8;
  localparam int RANDOM_REQS = 1880;
  localparam int HOLD_AFTER  = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT    = 1000;

  // Angle constants in Q.30 and the starting x of a rotation.
  localparam longint ANG_PI      = 64'sd3373259426;
  localparam longint ANG_TWO_PI  = 64'sd6746518852;
  localparam longint ANG_HALF_PI = 64'sd1686629713;
  localparam longint ROT_GAIN    = 64'sd652032874;
  localparam int     ARC_LEN     = 24;

  // Arctangent of 2^-k in Q.30.
  localparam longint ARC_Q30 [ARC_LEN] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
    64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
    64'sd1024,      64'sd512,       64'sd256,       64'sd128
  };

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // One directed request; the result is typed in only where it is obvious.
  typedef struct packed {
    point_t pt;
    logic   known;
    coord_t want;
  } stim_row_t;

  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    {16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0, 16'sd0, 16'sd0},
    {16'sd0,      16'sd32767,  16'h8000,    1'b1, 16'sd0, 16'sd0, 16'sd0},
    {16'sd0,      16'h8000,    16'sd32767,  1'b1, 16'sd0, 16'sd0, 16'sd0},
    {16'sd256,    16'sd0,      16'sd0,      1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd256,    16'sd0,      16'sd6434,   1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd256,    16'sd6434,   16'sd6434,   1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd256,    16'sd12868,  16'sd6434,   1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd256,    -16'sd12868, -16'sd6434,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd256,    16'sd12867,  16'sd12867,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd256,    16'sd12869,  -16'sd12869, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd256,    16'sd6433,   16'sd6435,   1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd256,    -16'sd6433,  -16'sd6435,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd32767,  16'sd0,      16'sd6434,   1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'h8000,    16'sd0,      16'sd0,      1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'h8000,    16'sd0,      16'sd12868,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'h8000,    16'sd0,      16'sd6434,   1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'h8000,    16'h8000,    16'h8000,    1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'h8000,    16'sd6434,   -16'sd6434,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd1,      16'sd3217,   16'sd3217,   1'b0, 16'sd0, 16'sd0, 16'sd0},
    {-16'sd1,     -16'sd3217,  16'sd9651,   1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd32767,  16'h8000,    16'sd0,      1'b0, 16'sd0, 16'sd0, 16'sd0},
    {16'sd12345,  16'sd25736,  -16'sd25736, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    {-16'sd256,   16'sd19302,  -16'sd19302, 1'b0, 16'sd0, 16'sd0, 16'sd0}
  };

  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   point_valid = 1'b0;
  logic   point_stall;
  point_t point       = '0;
  logic   coord_valid;
  logic   coord_stall = 1'b0;
  coord_t coord;

  coord_t pending_coords[$];
  int     errors      = 0;
  int     points_sent = 0;
  int     burst_left  = 0;

  spherical_to_cartesian #(.ROTATION_STEPS(ROT_STEPS)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .coord       (coord)
  );

  always #5 clk = ~clk;

  // Round a Q2.30 product back to Q2.30, ties toward +infinity.
  function automatic longint round_q30(input longint v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

  // Cosine and sine of a Q4.12 angle, both in Q2.30.
  function automatic void sin_cos_q30(input logic signed [15:0] ang,
                                      output longint cos_v, output longint sin_v);
    longint z, x, y, dx, dy, nx, ny;
    logic   flip;
    int     k;
    z    = longint'(ang) * 64'sd262144;
    flip = 1'b0;
    x    = ROT_GAIN;
    y    = 0;
    // Reduce into [-pi, pi], then fold into [-pi/2, pi/2].
    if (z > ANG_PI) begin
      z -= ANG_TWO_PI;
    end else if (z < -ANG_PI) begin
      z += ANG_TWO_PI;
    end
    if (z > ANG_HALF_PI) begin
      z -= ANG_PI;
      flip = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z += ANG_PI;
      flip = 1'b1;
    end
    for (k = 0; k < ROT_STEPS && k < ARC_LEN; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARC_Q30[k];
      end else begin
        x += dx;
        y -= dy;
        z += ARC_Q30[k];
      end
    end
    // First-order correction with the residual angle.
    nx = x - ((y * z) >>> 30);
    ny = y + ((x * z) >>> 30);
    x  = flip ? -nx : nx;
    y  = flip ? -ny : ny;
    cos_v = x;
    sin_v = y;
  endfunction

  // Radius in Q8.8 times a Q2.30 factor, rounded and saturated to Q8.8.
  function automatic logic signed [15:0] scale_q88(input longint rad, input longint f);
    longint v;
    v = round_q30(rad * f);
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  function automatic coord_t convert_point(input point_t p);
    longint cos_az, sin_az, cos_po, sin_po, rad;
    coord_t c;
    sin_cos_q30(p.azimuth, cos_az, sin_az);
    sin_cos_q30(p.polar, cos_po, sin_po);
    rad       = longint'(p.radius);
    c.coord_x = scale_q88(rad, round_q30(cos_az * sin_po));
    c.coord_y = scale_q88(rad, round_q30(sin_az * sin_po));
    c.coord_z = scale_q88(rad, cos_po);
    return c;
  endfunction

  // Offer one request in bursts with random gaps, then wait for acceptance.
  task automatic offer_point(input point_t p, input coord_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        point_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    point_valid <= 1'b1;
    point       <= p;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    pending_coords.push_back(want);
    points_sent++;
  endtask

  // Request source: reset, directed table, then random requests.
  initial begin : point_source
    point_t    p;
    stim_row_t row;
    int        n;
    int        sel;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < N_DIRECTED; n++) begin
      row = DIRECTED_ROWS[n];
      offer_point(row.pt, row.known ? row.want : convert_point(row.pt));
    end

    for (n = 0; n < RANDOM_REQS; n++) begin
      // Once, let the pipeline empty completely before going on.
      if (n == DRAIN_AT) begin
        point_valid <= 1'b0;
        while (pending_coords.size() != 0) @(posedge clk);
        burst_left = 0;
      end
      p   = point_t'({16'($urandom), 16'($urandom), 16'($urandom)});
      sel = $urandom_range(0, 19);
      // Some requests use an extreme radius or angles near a multiple of pi/2.
      if (sel < 3) begin
        case ($urandom_range(0, 6))
          0:       p.radius = 16'h8000;
          1:       p.radius = 16'sd32767;
          2:       p.radius = 16'sd0;
          3:       p.radius = 16'sd1;
          4:       p.radius = -16'sd1;
          5:       p.radius = 16'sd256;
          default: p.radius = -16'sd256;
        endcase
      end else if (sel < 6) begin
        p.azimuth = 16'(($urandom_range(0, 10) - 5) * 6434 + $urandom_range(0, 6) - 3);
        p.polar   = 16'(($urandom_range(0, 10) - 5) * 6434 + $urandom_range(0, 6) - 3);
      end
      offer_point(p, convert_point(p));
    end

    point_valid <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (errors == 0 && pending_coords.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Result side stall pattern, with one long hold while requests keep coming.
  initial begin : coord_sink
    stall_mode_t mode;
    int          span;
    int          phase;
    logic        held;
    held  = 1'b0;
    phase = 0;
    forever begin
      if (!held && points_sent >= HOLD_AFTER) begin
        held = 1'b1;
        coord_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(10, 120);
        repeat (span) begin
          case (mode)
            STALL_NONE:  coord_stall <= 1'b0;
            STALL_LIGHT: coord_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: coord_stall <= ($urandom_range(0, 3) != 0);
            default:     coord_stall <= (phase % 3 == 0);
          endcase
          phase++;
          @(posedge clk);
        end
      end
    end
  end

  // Compare each accepted result with the oldest pending expectation.
  always @(posedge clk) begin : coord_check
    coord_t want;
    if (!rst && coord_valid && !coord_stall) begin
      if (pending_coords.size() == 0) begin
        $error("coord: result with no request pending");
        errors++;
      end else begin
        want = pending_coords.pop_front();
        if (coord.coord_x !== want.coord_x) begin
          $error("coord_x: expected %0d, actual %0d", want.coord_x, coord.coord_x);
          errors++;
        end
        if (coord.coord_y !== want.coord_y) begin
          $error("coord_y: expected %0d, actual %0d", want.coord_y, coord.coord_y);
          errors++;
        end
        if (coord.coord_z !== want.coord_z) begin
          $error("coord_z: expected %0d, actual %0d", want.coord_z, coord.coord_z);
          errors++;
        end
      end
    end
  end

  // Give up if the run hangs.
  initial begin : watchdog
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

/* spherical_to_cartesian.f */
+incdir+rtl/core
rtl/core/s2c_pkg.sv
rtl/core/s2c_prep.sv
rtl/core/s2c_cell.sv
rtl/core/s2c_post.sv
rtl/core/spherical_to_cartesian.sv
tb/testbench.sv
